// ===== rtl/core/mcdic_pkg.sv =====
// Shared types and constants of the memory chain device id controller.
package mcdic_pkg;

  // Transaction payloads.
  typedef struct packed {
    logic [4:0]  operation;
    logic [4:0]  device_id;
    logic [8:0]  reg_index;
    logic        broadcast;
    logic [15:0] write_data;
    logic        spd_present;
    logic [7:0]  spd_byte;
    logic [8:0]  socket_count_sum;
  } cmd_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic        read_valid;
  } rsp_t;

  // Status of the shared id compare unit.
  typedef struct packed {
    logic in_range;
    logic match;
  } sweep_stat_t;

  // Width of device counts and of the sweep counter.
  localparam int CNT_W = 5;
  localparam int CTRL_REG_COUNT = 32;
  localparam logic [CNT_W-1:0] RESET_DEVICE_COUNT = 5'd8;

  // Operation codes.
  localparam logic [4:0] OP_READ        = 5'd0;
  localparam logic [4:0] OP_WRITE       = 5'd1;
  localparam logic [4:0] OP_SELECT_PAIR = 5'd8;
  localparam logic [4:0] OP_BCAST_RESET = 5'd9;
  localparam logic [4:0] OP_SPD_READ    = 5'd14;
  localparam logic [4:0] OP_CHAIN_RESET = 5'd17;

  // Register numbers.
  localparam logic [8:0] REG_SPD_STATUS = 9'h00a;
  localparam logic [8:0] REG_PWR_STATE  = 9'h00f;
  localparam logic [8:0] DEV_REG_BASE   = 9'h020;
  localparam logic [8:0] REG_DEV_ID     = 9'h021;
  localparam logic [8:0] REG_DEV_TYPE   = 9'h023;

  // Data words.
  localparam logic [15:0] ID_UNASSIGNED = 16'h001f;
  localparam logic [15:0] TYPE_WORD     = 16'h8001;
  localparam logic [15:0] NO_ANSWER     = 16'hffff;
  localparam logic [15:0] SPD_DONE      = 16'h8000;
  localparam logic [15:0] SPD_NONE      = 16'ha000;
  localparam logic [15:0] PWR_BUSY      = 16'h0008;
  localparam logic [15:0] PWR_OK        = 16'h0010;

endpackage

// ===== rtl/core/mcdic_sweep.sv =====
// Sweep counter and shared id compare unit that walks the device table.
module mcdic_sweep #(
  parameter int IDX_W = 5
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic                      advance,
  input  logic [mcdic_pkg::CNT_W-1:0] limit,
  input  logic [4:0]                target,
  input  logic [15:0]               entry_id,
  output logic [IDX_W-1:0]          idx,
  output mcdic_pkg::sweep_stat_t    stat
);

  logic [mcdic_pkg::CNT_W-1:0] idx_r;
  logic [mcdic_pkg::CNT_W-1:0] idx_nxt;

  always_comb begin
    idx_nxt = idx_r;
    if (start) begin
      idx_nxt = '0;
    end else if (advance) begin
      idx_nxt = idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

  assign idx           = idx_r[IDX_W-1:0];
  assign stat.in_range = (idx_r < limit);
  assign stat.match    = (entry_id[4:0] == target);

endmodule

// ===== rtl/core/memory_chain_device_id_controller_core.sv =====
// Top level of the memory chain device id controller.
//
// Commands arrive on the in_ channel (valid/ready) as one cmd_t transaction each,
// and every command returns exactly one rsp_t transaction on the out_ channel.
// read_valid marks serial reads; other commands return read_data of zero.
// The block handles one transaction at a time: in_ready is high only while idle.
// Controller register access, SPD status, pair select, writes of device registers
// other than the id register and no-op commands finish in the accept cycle, so
// their response is offered on the next cycle, and the block is idle again for the
// next command once out_ready has taken that response.
// Device reads, id register writes, broadcast reset and chain reset walk the table
// one entry per cycle through a single id comparator, up to the live count of entries.
// A lookup stops at the first live device whose low five id bits match.
// The response register holds its transaction while out_ready is low, and no new
// command is taken until it has been delivered.
// The cfg_ port loads the device count (clamped to 1..MAX_DEVICES) at once; write
// it only while idle. Synchronous reset restores all ids to unassigned, clears the
// controller registers, SPD status and pair, and loads a count of eight (at most MAX_DEVICES).
module memory_chain_device_id_controller_core #(
  parameter int MAX_DEVICES = 31
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mcdic_pkg::cmd_t     in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mcdic_pkg::rsp_t     out_data,
  input  logic                cfg_wr_en,
  input  logic [4:0]          cfg_wr_data
);

  localparam int IDX_W = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
  localparam logic [mcdic_pkg::CNT_W-1:0] MAX_CNT = mcdic_pkg::CNT_W'(MAX_DEVICES);

  typedef enum logic [1:0] {S_IDLE, S_SWEEP, S_OUT} state_t;
  // What the table walk does at each entry.
  typedef enum logic [1:0] {K_READ, K_WRITE_ONE, K_WRITE_ALL, K_UNASSIGN} kind_t;

  state_t                         state_r, state_nxt;
  kind_t                          kind_r, kind_nxt;
  mcdic_pkg::cmd_t                cmd_r, cmd_nxt;
  mcdic_pkg::rsp_t                out_r, out_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [mcdic_pkg::CNT_W-1:0]    live_r, live_nxt;
  logic [15:0]                    spd_r, spd_nxt;
  logic [4:0]                     pair_r, pair_nxt;

  logic [15:0] ids_r  [MAX_DEVICES];
  logic [15:0] ctrl_r [mcdic_pkg::CTRL_REG_COUNT];

  logic        ctrl_we;
  logic [15:0] ctrl_wdata;
  logic        id_we;
  logic [15:0] id_wdata;
  logic        sw_start;
  logic        sw_adv;
  logic [IDX_W-1:0]       sw_idx;
  logic [15:0]            sw_entry;
  mcdic_pkg::sweep_stat_t sw_stat;

  logic [mcdic_pkg::CNT_W-1:0] cfg_count;
  logic [mcdic_pkg::CNT_W-1:0] sum_count;

  // The configured count is clamped to the legal range of the chain.
  always_comb begin
    if (cfg_wr_data == '0) begin
      cfg_count = 5'd1;
    end else if (cfg_wr_data > MAX_CNT) begin
      cfg_count = MAX_CNT;
    end else begin
      cfg_count = cfg_wr_data;
    end
  end

  // The summed socket counts saturate at the table depth; zero is allowed.
  assign sum_count = (in_data.socket_count_sum > 9'(MAX_DEVICES)) ? MAX_CNT :
                     in_data.socket_count_sum[mcdic_pkg::CNT_W-1:0];

  assign sw_entry = ids_r[sw_idx];

  mcdic_sweep #(
    .IDX_W(IDX_W)
  ) u_sweep (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (sw_start),
    .advance (sw_adv),
    .limit   (live_r),
    .target  (cmd_r.device_id),
    .entry_id(sw_entry),
    .idx     (sw_idx),
    .stat    (sw_stat)
  );

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    cmd_nxt       = cmd_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    live_nxt      = live_r;
    spd_nxt       = spd_r;
    pair_nxt      = pair_r;
    ctrl_we       = 1'b0;
    ctrl_wdata    = in_data.write_data;
    id_we         = 1'b0;
    id_wdata      = cmd_r.write_data;
    sw_start      = 1'b0;
    sw_adv        = 1'b0;

    if (cfg_wr_en) begin
      live_nxt = cfg_count;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt       = in_data;
          out_nxt       = '0;
          state_nxt     = S_OUT;
          out_valid_nxt = 1'b1;
          case (in_data.operation)
            mcdic_pkg::OP_READ: begin
              out_nxt.read_valid = 1'b1;
              if (in_data.reg_index < mcdic_pkg::DEV_REG_BASE) begin
                out_nxt.read_data = (in_data.reg_index == mcdic_pkg::REG_SPD_STATUS) ?
                                    spd_r : ctrl_r[in_data.reg_index[4:0]];
              end else begin
                // Answer stays all ones unless a live device matches.
                out_nxt.read_data = mcdic_pkg::NO_ANSWER;
                kind_nxt          = K_READ;
                sw_start          = 1'b1;
                state_nxt         = S_SWEEP;
                out_valid_nxt     = 1'b0;
              end
            end
            mcdic_pkg::OP_WRITE: begin
              if (in_data.reg_index < mcdic_pkg::DEV_REG_BASE) begin
                ctrl_we = 1'b1;
                if (in_data.reg_index == mcdic_pkg::REG_PWR_STATE) begin
                  // Power-state write retires busy and reports the state as good.
                  ctrl_wdata = (in_data.write_data & ~mcdic_pkg::PWR_BUSY) |
                               mcdic_pkg::PWR_OK;
                end
              end else if (in_data.reg_index == mcdic_pkg::REG_DEV_ID) begin
                kind_nxt      = in_data.broadcast ? K_WRITE_ALL : K_WRITE_ONE;
                sw_start      = 1'b1;
                state_nxt     = S_SWEEP;
                out_valid_nxt = 1'b0;
              end
            end
            mcdic_pkg::OP_SELECT_PAIR: begin
              if (pair_r != in_data.device_id) begin
                pair_nxt = in_data.device_id;
                live_nxt = sum_count;
              end
            end
            mcdic_pkg::OP_BCAST_RESET: begin
              kind_nxt      = K_UNASSIGN;
              sw_start      = 1'b1;
              state_nxt     = S_SWEEP;
              out_valid_nxt = 1'b0;
            end
            mcdic_pkg::OP_SPD_READ: begin
              spd_nxt = in_data.spd_present ?
                        (mcdic_pkg::SPD_DONE | {8'h00, in_data.spd_byte}) :
                        mcdic_pkg::SPD_NONE;
            end
            mcdic_pkg::OP_CHAIN_RESET: begin
              // The new count bounds the unassign walk that follows.
              live_nxt      = sum_count;
              kind_nxt      = K_UNASSIGN;
              sw_start      = 1'b1;
              state_nxt     = S_SWEEP;
              out_valid_nxt = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      S_SWEEP: begin
        if (!sw_stat.in_range) begin
          state_nxt     = S_OUT;
          out_valid_nxt = 1'b1;
        end else begin
          case (kind_r)
            K_READ: begin
              if (sw_stat.match) begin
                if (cmd_r.reg_index == mcdic_pkg::REG_DEV_ID) begin
                  out_nxt.read_data = sw_entry;
                end else if (cmd_r.reg_index == mcdic_pkg::REG_DEV_TYPE) begin
                  out_nxt.read_data = mcdic_pkg::TYPE_WORD;
                end else begin
                  out_nxt.read_data = '0;
                end
                state_nxt     = S_OUT;
                out_valid_nxt = 1'b1;
              end else begin
                sw_adv = 1'b1;
              end
            end
            K_WRITE_ONE: begin
              if (sw_stat.match) begin
                id_we         = 1'b1;
                state_nxt     = S_OUT;
                out_valid_nxt = 1'b1;
              end else begin
                sw_adv = 1'b1;
              end
            end
            K_WRITE_ALL: begin
              id_we  = 1'b1;
              sw_adv = 1'b1;
            end
            K_UNASSIGN: begin
              id_we    = 1'b1;
              id_wdata = mcdic_pkg::ID_UNASSIGNED;
              sw_adv   = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      S_OUT: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Sequencer state, command copy and response register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      kind_r      <= K_READ;
      out_valid_r <= 1'b0;
      live_r      <= (mcdic_pkg::RESET_DEVICE_COUNT > MAX_CNT) ? MAX_CNT :
                     mcdic_pkg::RESET_DEVICE_COUNT;
      spd_r       <= '0;
      pair_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      kind_r      <= kind_nxt;
      out_valid_r <= out_valid_nxt;
      live_r      <= live_nxt;
      spd_r       <= spd_nxt;
      pair_r      <= pair_nxt;
    end
    cmd_r <= cmd_nxt;
    out_r <= out_nxt;
  end

  // Device id table, written by the walk one entry per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_DEVICES; i++) begin
        ids_r[i] <= mcdic_pkg::ID_UNASSIGNED;
      end
    end else if (id_we) begin
      ids_r[sw_idx] <= id_wdata;
    end
  end

  // Controller register file.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < mcdic_pkg::CTRL_REG_COUNT; i++) begin
        ctrl_r[i] <= '0;
      end
    end else if (ctrl_we) begin
      ctrl_r[in_data.reg_index[4:0]] <= ctrl_wdata;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // A command is never taken while a response is still on offer.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input accepted while a response is pending");

  // Once a transaction is accepted the block is busy on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready stayed high after an accepted transaction");

  // Only serial reads carry data.
  a_non_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.read_valid) |-> (out_data.read_data == '0))
    else $error("non-read response carries data");

  // The live count never exceeds the table depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    live_r <= MAX_CNT)
    else $error("live device count beyond table depth");

endmodule
